/* hw/rtl/olist_pkg.sv */
// Shared types and constants for the ordered array list engine.
`default_nettype none

package olist_pkg;

    localparam int DATA_W   = 32;
    localparam int OP_W     = 3;
    localparam int POS_W    = 5;
    localparam int STATUS_W = 2;

    // Request opcodes
    localparam logic [OP_W-1:0] OP_INSERT     = 3'd0;
    localparam logic [OP_W-1:0] OP_DEL_VALUE  = 3'd1;
    localparam logic [OP_W-1:0] OP_DEL_POS    = 3'd2;
    localparam logic [OP_W-1:0] OP_SEARCH     = 3'd3;
    localparam logic [OP_W-1:0] OP_READ       = 3'd4;
    localparam logic [OP_W-1:0] OP_CLEAR      = 3'd5;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_BAD_POS   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd3;

    // Command broadcast to every cell of the chain
    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_DELETE,
        CELL_COMPARE,
        CELL_SHIFT
    } cell_op_t;

    typedef struct packed {
        cell_op_t                  op;
        logic signed [DATA_W-1:0]  value;
    } cell_cmd_t;

endpackage

`default_nettype wire

/* hw/rtl/olist_cell.sv */
// One list slot: holds an element and a match flag, trades both with its neighbors.
`default_nettype none

module olist_cell #(
    parameter int CAPACITY = 16,
    parameter int INDEX    = 0
) (
    input  wire                                     clk,
    input  olist_pkg::cell_cmd_t                    cmd,
    input  wire [$clog2(CAPACITY)-1:0]              target,
    input  wire signed [olist_pkg::DATA_W-1:0]      left_data,
    input  wire signed [olist_pkg::DATA_W-1:0]      right_data,
    input  wire                                     right_match,
    output logic signed [olist_pkg::DATA_W-1:0]     data,
    output logic                                    match
);
    import olist_pkg::*;

    localparam int IDX_W = $clog2(CAPACITY);
    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

    logic signed [DATA_W-1:0] data_reg;
    logic                     match_reg;

    always_ff @(posedge clk)
    begin
        case (cmd.op)
            CELL_INSERT:
            begin
                if (MY_IDX == target)
                    data_reg <= cmd.value;
                else if (MY_IDX > target)
                    data_reg <= left_data;
            end
            CELL_DELETE:
            begin
                if (MY_IDX >= target)
                    data_reg <= right_data;
            end
            CELL_COMPARE:
            begin
                match_reg <= (data_reg == cmd.value);
            end
            CELL_SHIFT:
            begin
                // match flags move one slot toward the head
                match_reg <= right_match;
            end
            default:
            begin
            end
        endcase
    end

    assign data  = data_reg;
    assign match = match_reg;

endmodule

`default_nettype wire

/* hw/rtl/ordered_array_list_engine.sv */
// Top level of the ordered array list engine: control sequencer and the cell chain.
// Insert, delete at position, read, clear and unknown ops give the result in the cycle
// after the transfer with busy low, so one such request is taken per cycle.
// Search and delete by value compare all slots at once, then the match flags walk the
// cell chain toward the head one slot a cycle, busy high, until a match or the list end.
// Reset clears length, sequencer and done; element contents are not. Results never stall.
`default_nettype none

module ordered_array_list_engine #(
    parameter int CAPACITY = 16
) (
    input  wire                                     clk,
    input  wire                                     rst_n,
    input  wire                                     start,
    output logic                                    busy,
    input  wire [olist_pkg::OP_W-1:0]               op,
    input  wire [olist_pkg::POS_W-1:0]              position,
    input  wire signed [olist_pkg::DATA_W-1:0]      value,
    output logic                                    done,
    output logic [olist_pkg::STATUS_W-1:0]          status,
    output logic [olist_pkg::POS_W-1:0]             found_position,
    output logic signed [olist_pkg::DATA_W-1:0]    read_value,
    output logic [olist_pkg::POS_W-1:0]             length,
    output logic                                    list_empty,
    output logic                                    is_full
);
    import olist_pkg::*;

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);
    // compare width wide enough for position, count and count+1
    localparam int CMP_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(CAPACITY);

    typedef enum logic {
        S_IDLE,
        S_SCAN
    } state_t;

    state_t                    state_reg, state_next;
    logic [CNT_W-1:0]          count_reg, count_next;
    logic [IDX_W-1:0]          scan_reg, scan_next;
    logic                      del_reg, del_next;    // scan belongs to a delete by value

    logic                      done_reg, done_next;
    logic [STATUS_W-1:0]       status_reg, status_next;
    logic [POS_W-1:0]          found_reg, found_next;
    logic signed [DATA_W-1:0]  read_reg, read_next;

    cell_cmd_t                 cmd;
    logic [IDX_W-1:0]          target;

    logic signed [DATA_W-1:0]  cell_data  [CAPACITY];
    logic                      cell_match [CAPACITY];

    logic                      accept;
    logic [CMP_W-1:0]          pos_ext;
    logic [CMP_W-1:0]          cnt_ext;
    logic [CMP_W-1:0]          pos_m1;
    logic [IDX_W-1:0]          pos_idx;
    logic                      pos_in_list;      // 1..length
    logic                      pos_in_insert;    // 1..length+1
    logic [IDX_W:0]            scan_pos;
    logic                      scan_last;

    assign accept  = start && (state_reg == S_IDLE);
    assign pos_ext = CMP_W'(position);
    assign cnt_ext = CMP_W'(count_reg);
    assign pos_m1  = pos_ext - CMP_W'(1);
    assign pos_idx = pos_m1[IDX_W-1:0];

    assign pos_in_list   = (position != '0) && (pos_ext <= cnt_ext);
    assign pos_in_insert = (position != '0) && (pos_ext <= cnt_ext + CMP_W'(1));

    assign scan_pos  = {1'b0, scan_reg} + (IDX_W + 1)'(1);
    assign scan_last = (CNT_W'(scan_pos) == count_reg);

    // ------------------------------------------------------------------
    // Sequencer and result logic
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        scan_next   = scan_reg;
        del_next    = del_reg;
        done_next   = 1'b0;
        status_next = ST_OK;
        found_next  = '0;
        read_next   = '0;
        cmd.op      = CELL_HOLD;
        cmd.value   = value;
        target      = pos_idx;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (op)
                        OP_INSERT:
                        begin
                            done_next = 1'b1;
                            if (!pos_in_insert)
                                status_next = ST_BAD_POS;
                            else if (count_reg == CNT_FULL)
                                status_next = ST_FULL;
                            else
                            begin
                                cmd.op     = CELL_INSERT;
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        OP_DEL_POS:
                        begin
                            done_next = 1'b1;
                            if (!pos_in_list)
                                status_next = ST_BAD_POS;
                            else
                            begin
                                cmd.op     = CELL_DELETE;
                                count_next = count_reg - CNT_W'(1);
                            end
                        end
                        OP_READ:
                        begin
                            done_next = 1'b1;
                            if (!pos_in_list)
                                status_next = ST_BAD_POS;
                            else
                                read_next = cell_data[pos_idx];
                        end
                        OP_CLEAR:
                        begin
                            done_next  = 1'b1;
                            count_next = '0;
                        end
                        OP_SEARCH, OP_DEL_VALUE:
                        begin
                            if (count_reg == '0)
                            begin
                                // empty list: nothing can match
                                done_next   = 1'b1;
                                status_next = ST_NOT_FOUND;
                            end
                            else
                            begin
                                cmd.op     = CELL_COMPARE;
                                scan_next  = '0;
                                del_next   = (op == OP_DEL_VALUE);
                                state_next = S_SCAN;
                            end
                        end
                        default:
                        begin
                            // unknown opcode: no change, status ok
                            done_next = 1'b1;
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                // cell 0 holds the match flag of list slot scan_reg
                target = scan_reg;
                if (cell_match[0])
                begin
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                    if (del_reg)
                    begin
                        cmd.op     = CELL_DELETE;
                        count_next = count_reg - CNT_W'(1);
                    end
                    else
                        found_next = POS_W'(scan_pos);
                end
                else if (scan_last)
                begin
                    done_next   = 1'b1;
                    status_next = ST_NOT_FOUND;
                    state_next  = S_IDLE;
                end
                else
                begin
                    cmd.op    = CELL_SHIFT;
                    scan_next = scan_reg + IDX_W'(1);
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            count_reg  <= '0;
            scan_reg   <= '0;
            del_reg    <= 1'b0;
            done_reg   <= 1'b0;
            status_reg <= ST_OK;
            found_reg  <= '0;
            read_reg   <= '0;
            length     <= '0;
            list_empty <= 1'b1;
            is_full    <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            scan_reg   <= scan_next;
            del_reg    <= del_next;
            done_reg   <= done_next;
            if (done_next)
            begin
                status_reg <= status_next;
                found_reg  <= found_next;
                read_reg   <= read_next;
                length     <= POS_W'(count_next);
                list_empty <= (count_next == '0);
                is_full    <= (count_next == CNT_FULL);
            end
        end
    end

    assign busy           = (state_reg != S_IDLE);
    assign done           = done_reg;
    assign status         = status_reg;
    assign found_position = found_reg;
    assign read_value     = read_reg;

    // ------------------------------------------------------------------
    // Cell chain: slot 0 is the list head
    // ------------------------------------------------------------------
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic signed [DATA_W-1:0] left_d;
        logic signed [DATA_W-1:0] right_d;
        logic                     right_m;

        if (i == 0)
        begin : g_head
            assign left_d = cmd.value;
        end
        else
        begin : g_body
            assign left_d = cell_data[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_tail
            assign right_d = cell_data[i];
            assign right_m = 1'b0;
        end
        else
        begin : g_inner
            assign right_d = cell_data[i+1];
            assign right_m = cell_match[i+1];
        end

        olist_cell #(
            .CAPACITY (CAPACITY),
            .INDEX    (i)
        ) u_cell (
            .clk         (clk),
            .cmd         (cmd),
            .target      (target),
            .left_data   (left_d),
            .right_data  (right_d),
            .right_match (right_m),
            .data        (cell_data[i]),
            .match       (cell_match[i])
        );
    end

endmodule

`default_nettype wire
